// ----- sv/staging_ring_allocator_top_defines.svh -----
// ----------------------------------------------------------------------------
// staging_ring_allocator_top_defines
// assertion macros for the staging ring allocator
// ----------------------------------------------------------------------------
`ifndef STAGING_RING_ALLOCATOR_TOP_DEFINES_SVH
`define STAGING_RING_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SRA_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define SRA_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define SRA_ASSERT_IMPL(label, clk, rst_n, a, c, msg)
`define SRA_ASSERT_NEXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// ----- sv/sra_pkg.sv -----
// ----------------------------------------------------------------------------
// sra_pkg
// shared types and codes of the staging ring allocator
// ----------------------------------------------------------------------------
package sra_pkg;
    localparam logic [1:0] ST_GRANTED  = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_FIFO     = 2'd3;
    localparam logic       REQ_ALLOC   = 1'b0;
    localparam logic       REQ_RESET   = 1'b1;
    localparam logic [0:0] REG_CAP     = 1'b0;
    localparam logic [0:0] REG_BASE    = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // capture request fields
        logic empty;     // empty ring
        logic rd_first;  // issue read of oldest entry
        logic pop;       // pop oldest entry (read data valid)
        logic renorm;    // renormalize if fifo empty
        logic div_start; // start head % cap
        logic rd_last;   // issue read of newest entry
        logic decide;    // evaluate and commit
        logic out_load;  // load result register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic req_reset;
        logic fifo_empty;
        logic can_pop;
        logic div_done;
        logic bad_size;
    } t_sts;
endpackage

// ----- sv/sra_ram.sv -----
// ----------------------------------------------------------------------------
// sra_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
module sra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ----- sv/sra_div.sv -----
// ----------------------------------------------------------------------------
// sra_div
// restoring divider, 64 by 32 bit remainder, one bit per cycle
// ----------------------------------------------------------------------------
module sra_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_rem
);
    logic [63:0] r_num;
    logic [32:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_try;
    logic [33:0] w_diff;

    // shift next bit in and trial subtract
    assign w_try  = {r_rem[31:0], r_num[63]};
    assign w_diff = {1'b0, w_try} - {2'b00, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_num  <= i_dividend;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[62:0], 1'b0};
                r_rem <= w_diff[33] ? w_try : w_diff[32:0];
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_rem  = r_rem[31:0];
endmodule

// ----- sv/sra_ctrl.sv -----
// ----------------------------------------------------------------------------
// sra_ctrl
// sequencer for one request: reclaim walk, modulo, decision, output
// ----------------------------------------------------------------------------
module sra_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_busy,
    input  sra_pkg::t_sts i_sts,
    output sra_pkg::t_cmd o_cmd
);
    import sra_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_LAST  = 3'd4;
    localparam logic [2:0] S_DEC   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                if (i_sts.req_reset) begin
                    o_cmd.empty = 1'b1;
                    n_state     = S_OUT;
                end else if (i_sts.fifo_empty) begin
                    o_cmd.renorm = 1'b1;
                    n_state      = S_DIV;
                end else begin
                    o_cmd.rd_first = 1'b1;
                    n_state        = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.can_pop) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_RD;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.bad_size) begin
                    n_state = S_DEC;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_LAST;
                end
            end
            S_LAST: begin
                o_cmd.rd_last = 1'b1;
                if (i_sts.div_done) n_state = S_DEC;
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                n_state      = S_OUT;
            end
            // hold the result until the output register is free
            S_OUT: begin
                if (!i_out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ----- sv/sra_dp.sv -----
// ----------------------------------------------------------------------------
// sra_dp
// ring pointers, region fifo, divider and result register
// ----------------------------------------------------------------------------
module sra_dp #(
    parameter int FIFO_DEPTH  = 64,
    parameter int ALIGN_BYTES = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sra_pkg::t_cmd i_cmd,
    output sra_pkg::t_sts o_sts,
    input  logic          i_req_type,
    input  logic [31:0]   i_alloc_size,
    input  logic          i_sync_consumer,
    input  logic [31:0]   i_open_batch,
    input  logic [31:0]   i_retired_below,
    input  logic [31:0]   i_cap,
    input  logic [31:0]   i_base,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [1:0]    o_status,
    output logic [32:0]   o_offset
);
    import sra_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int SW = $clog2(ALIGN_BYTES);

    logic          r_req;
    logic [31:0]   r_size, r_sub, r_ret;
    logic          r_sync;
    logic [63:0]   r_head, r_tail;
    logic [AW-1:0] r_first;
    logic [CW-1:0] r_count;
    logic [1:0]    r_status;
    logic [32:0]   r_offset;
    logic          r_valid;
    logic [32:0]   r_gout;
    logic [1:0]    r_gst;

    logic [AW-1:0] w_raddr, w_waddr, w_last;
    logic [63:0]   w_end_rd, w_end_wd;
    logic [32:0]   w_con_rd, w_con_wd;
    logic          w_we;
    logic          w_div_done;
    logic [31:0]   w_rem;
    logic [32:0]   w_need;
    logic [32:0]   w_pad;
    logic [63:0]   w_hd, w_endp;
    logic [63:0]   w_used;
    logic [32:0]   w_tag;
    logic          w_merge;

    // rounded size: add align-1 and clear low bits
    always_comb begin
        w_need = {1'b0, r_size} + 33'(ALIGN_BYTES - 1);
        if (SW > 0) w_need = (w_need >> SW) << SW;
    end

    sra_ram #(.WIDTH(64), .DEPTH(FIFO_DEPTH)) u_end (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_end_wd),
        .i_raddr(w_raddr), .o_rdata(w_end_rd));
    sra_ram #(.WIDTH(33), .DEPTH(FIFO_DEPTH)) u_con (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_con_wd),
        .i_raddr(w_raddr), .o_rdata(w_con_rd));

    sra_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_dividend(r_head), .i_divisor(i_cap), .o_done(w_div_done),
        .o_rem(w_rem));

    // fifo addressing
    always_comb begin
        logic [CW:0] s;
        s       = {1'b0, r_count} + CW'(r_first) - (CW+1)'(1);
        w_last  = AW'(s % FIFO_DEPTH);
        s       = {1'b0, r_count} + CW'(r_first);
        w_waddr = w_merge ? w_last : AW'(s % FIFO_DEPTH);
        w_raddr = i_cmd.rd_last ? w_last : r_first;
    end

    // placement and fit
    always_comb begin
        w_pad  = {1'b0, w_rem} + w_need;
        w_hd   = r_head;
        if (w_pad > {1'b0, i_cap}) w_hd = r_head + 64'(i_cap - w_rem);
        w_endp = w_hd + 64'(w_need);
        w_used = w_endp - r_tail;
        w_tag  = r_sync ? {1'b1, 32'd0} : {1'b0, r_sub};
        w_merge = (r_count != '0) && (w_con_rd == w_tag) && (w_end_rd == r_head);
        w_end_wd = w_endp;
        w_con_wd = w_tag;
    end

    logic w_bad, w_full, w_ffull, w_ok;
    assign w_bad   = (w_need == '0) || (w_need > {1'b0, i_cap});
    assign w_full  = w_used > 64'(i_cap);
    assign w_ffull = !w_merge && (r_count == CW'(FIFO_DEPTH));
    assign w_ok    = !w_bad && !w_full && !w_ffull;
    assign w_we    = i_cmd.decide && w_ok;

    // status to controller
    assign o_sts.req_reset  = r_req;
    assign o_sts.fifo_empty = (r_count == '0);
    assign o_sts.can_pop    = w_con_rd[32] ||
                              ((w_con_rd[31:0] < r_sub) && (w_con_rd[31:0] < r_ret));
    assign o_sts.div_done   = w_div_done;
    assign o_sts.bad_size   = w_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_first <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_req  <= i_req_type;
                r_size <= i_alloc_size;
                r_sync <= i_sync_consumer;
                r_sub  <= i_open_batch;
                r_ret  <= i_retired_below;
                r_gst  <= ST_GRANTED;
                r_gout <= '0;
            end
            if (i_cmd.empty) begin
                r_head  <= '0;
                r_tail  <= '0;
                r_first <= '0;
                r_count <= '0;
            end
            if (i_cmd.pop) begin
                r_tail  <= w_end_rd;
                r_first <= (r_first == AW'(FIFO_DEPTH - 1)) ? '0 : r_first + AW'(1);
                r_count <= r_count - CW'(1);
                if (r_count == CW'(1)) begin
                    r_head  <= '0;
                    r_tail  <= '0;
                    r_first <= '0;
                end
            end
            if (i_cmd.renorm) begin
                r_head  <= '0;
                r_tail  <= '0;
                r_first <= '0;
            end
            if (i_cmd.decide) begin
                if (w_bad)       r_gst <= ST_BAD_SIZE;
                else if (w_full) r_gst <= ST_FULL;
                else if (w_ffull) r_gst <= ST_FIFO;
                else begin
                    r_gst  <= ST_GRANTED;
                    // a padded head sits on the wrap point, physical offset zero
                    r_gout <= {1'b0, i_base}
                              + {1'b0, (w_pad > {1'b0, i_cap}) ? 32'd0 : w_rem};
                    r_head <= w_endp;
                    if (!w_merge) r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_valid  <= 1'b1;
                r_status <= r_gst;
                r_offset <= r_gout;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_status    = r_status;
    assign o_offset    = r_offset;
endmodule

// ----- sv/staging_ring_allocator_top.sv -----
// ----------------------------------------------------------------------------
// staging_ring_allocator_top
// ring buffer allocator with in-order reclaim of retired regions
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_axis    in   tvalid/tready      tuser req_type, tdata size/sync/batch/ret
// m_axis    out  tvalid/tready      tdata status, offset
// apb       in   psel/penable       ring_capacity, base_offset
// an allocation first reclaims retired regions in order, until the walk stops
// at a live region or an empty fifo, then runs the 64-step modulo divider
// before the decision; a bad size skips the divider
// a reset request empties the ring; a request is taken while a result waits,
// and its result is held until the output register is free
// reset is synchronous and empties the ring
`include "staging_ring_allocator_top_defines.svh"
module staging_ring_allocator_top #(
    parameter int FIFO_DEPTH  = 64,
    parameter int ALIGN_BYTES = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic         s_axis_tuser,   // req_type
    input  logic [103:0] s_axis_tdata,   // alloc_size, sync_consumer, open_batch,
                                         // retired_below, zero fill
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,   // status, offset, zero fill
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import sra_pkg::*;

    logic [31:0] r_cap, r_base;
    t_cmd        w_cmd;
    t_sts        w_sts;
    logic [1:0]  w_status;
    logic [32:0] w_offset;
    logic        w_stall;
    logic        w_fail;

    // configuration registers
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= '0;
            r_base <= '0;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_CAP)  r_cap  <= pwdata;
            if (paddr[2] == REG_BASE) r_base <= pwdata;
        end
    end
    assign prdata = (paddr[2] == REG_BASE) ? r_base : r_cap;

    sra_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready), .i_out_busy(m_axis_tvalid),
        .i_sts(w_sts), .o_cmd(w_cmd));

    sra_dp #(.FIFO_DEPTH(FIFO_DEPTH), .ALIGN_BYTES(ALIGN_BYTES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_req_type(s_axis_tuser), .i_alloc_size(s_axis_tdata[31:0]),
        .i_sync_consumer(s_axis_tdata[32]), .i_open_batch(s_axis_tdata[64:33]),
        .i_retired_below(s_axis_tdata[96:65]), .i_cap(r_cap), .i_base(r_base),
        .i_out_ready(m_axis_tready), .o_out_valid(m_axis_tvalid),
        .o_status(w_status), .o_offset(w_offset));

    assign m_axis_tdata = {5'd0, w_offset, w_status};

    // checks on the result channel
    assign w_stall = m_axis_tvalid && !m_axis_tready;
    assign w_fail  = m_axis_tvalid && (w_status != ST_GRANTED);

    `SRA_ASSERT_NEXT(a_out_keep, i_clk, i_rst_n, w_stall, m_axis_tvalid, "result dropped")
    `SRA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, $stable(m_axis_tdata), "result changed")
    `SRA_ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, w_fail, w_offset == 33'd0, "failure offset")
endmodule
